>>> rtl/core/bf7_pkg.sv
// shared constants, types and weight tables for the 7x7 bilateral filter
// no dependencies; used by bf7_front, bf7_back and bilateral_filter_7x7
`timescale 1ns / 1ps

package bf7_pkg;

  localparam int RADIUS      = 3;
  localparam int DIAM        = 2 * RADIUS + 1;
  localparam int TAPS        = DIAM * DIAM;
  localparam int TAP_IDX_W   = $clog2(TAPS);
  localparam int DIAM_W      = $clog2(DIAM);
  localparam int RING_ROWS   = 2 * RADIUS + 3;
  localparam int PIX_W       = 8;
  localparam int LANES       = 3;
  localparam int PIXEL_W     = LANES * PIX_W;
  localparam int BIT_CNT_W   = $clog2(PIX_W);
  localparam int WEIGHT_BITS = 16;
  localparam int RANGE_N     = 1 << PIX_W;
  localparam int SPACE_N     = 2 * RADIUS * RADIUS + 1;
  localparam int DEN_W       = 22;
  localparam int NUM_W       = DEN_W + PIX_W;
  localparam int ROW_W       = 12;
  localparam int FW_W        = 11;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = ROW_W'(480);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_COLOR_MODE   = 2'd2
  } reg_index_t;

  // e^(-1/1250) and e^(-1/162) in q31, from a floored taylor sum
  localparam logic [63:0] ONE_Q31       = 64'd1 << 31;
  localparam logic [63:0] EXP_COLOR_Q31 = 64'd2145766349;
  localparam logic [63:0] EXP_SPACE_Q31 = 64'd2134268406;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef weight_t range_tab_t [RANGE_N];
  typedef weight_t tap_tab_t [TAPS];

  typedef struct packed {
    logic interior;
    logic frame_end;
    logic color;
  } job_ctrl_t;

  function automatic logic [63:0] mul_q31(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b + (64'd1 << 30);
    return p >> 31;
  endfunction

  function automatic weight_t to_weight(logic [63:0] g);
    logic [63:0] w;
    logic [63:0] mx;
    mx = (64'd1 << WEIGHT_BITS) - 64'd1;
    w  = (g + (64'd1 << (30 - WEIGHT_BITS))) >> (31 - WEIGHT_BITS);
    if (w > mx) w = mx;
    return w[WEIGHT_BITS-1:0];
  endfunction

  function automatic range_tab_t build_range();
    range_tab_t  tab;
    logic [63:0] c2;
    logic [63:0] g;
    logic [63:0] m;
    c2 = mul_q31(EXP_COLOR_Q31, EXP_COLOR_Q31);
    g  = ONE_Q31;
    m  = EXP_COLOR_Q31;
    for (int d = 0; d < RANGE_N; d++) begin
      tab[d] = to_weight(g);
      g = mul_q31(g, m);
      m = mul_q31(m, c2);
    end
    return tab;
  endfunction

  function automatic tap_tab_t build_taps();
    tap_tab_t    tab;
    weight_t     sp [SPACE_N];
    logic [63:0] g;
    int          di;
    int          dj;
    g = ONE_Q31;
    for (int d = 0; d < SPACE_N; d++) begin
      sp[d] = to_weight(g);
      g = mul_q31(g, EXP_SPACE_Q31);
    end
    for (int i = 0; i < DIAM; i++) begin
      for (int j = 0; j < DIAM; j++) begin
        di = i - RADIUS;
        dj = j - RADIUS;
        tab[i * DIAM + j] = sp[di * di + dj * dj];
      end
    end
    return tab;
  endfunction

  localparam range_tab_t RANGE_W = build_range();
  localparam tap_tab_t   TAP_W   = build_taps();

endpackage

>>> rtl/core/bilateral_filter_7x7.sv
// top level of the 7x7 bilateral filter: front end, job queue and filter engine
// depends on bf7_pkg, bf7_front, bf7_queue and bf7_back
`timescale 1ns / 1ps

// usage
//   pixel channel: pix_valid/pix_ready with op, chan0..chan2; op pixel writes one
//   pixel into the ring of nine line stores, op drain flushes one pending result
//   of an already finished frame
//   result channel: res_valid/res_ready with out0..out2 and frame_end, raster order,
//   radius rows plus radius pixels behind the input
//   config port: cfg_we, cfg_index, cfg_data; frame_width, frame_height, color_mode
//   engine: one job at a time, one result per job; an interior pixel passes through
//   job pop, centre read, the window reads of all taps from the single ring read
//   port, the read pipe, 8 divider steps and result load; a border pixel skips the window
//   pixels that produce no result are taken one per cycle while the queue has room
//   reset clears counters and loads 640x480 gray; the ring needs no clearing pass
//   a stalled receiver holds the result register; the engine waits, the job queue
//   fills and then pix_ready drops

module bilateral_filter_7x7 #(
  parameter int MAX_WIDTH = 1024,
  parameter int JOB_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bf7_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bf7_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic                          op,
  input  logic [bf7_pkg::PIX_W-1:0]     chan0,
  input  logic [bf7_pkg::PIX_W-1:0]     chan1,
  input  logic [bf7_pkg::PIX_W-1:0]     chan2,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [bf7_pkg::PIX_W-1:0]     out0,
  output logic [bf7_pkg::PIX_W-1:0]     out1,
  output logic [bf7_pkg::PIX_W-1:0]     out2,
  output logic                          frame_end
);

  localparam int RING  = bf7_pkg::RING_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(RING);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CTL_W = $bits(bf7_pkg::job_ctrl_t);
  localparam int JOB_W = CTL_W + WW + AW;

  logic                        q_full;
  logic                        push;
  logic [AW-1:0]               push_q;
  logic [WW-1:0]               push_w;
  bf7_pkg::job_ctrl_t          push_ctrl;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [bf7_pkg::PIXEL_W-1:0] mem_data;
  logic                        job_valid;
  logic                        job_pop;
  logic [JOB_W-1:0]            job_head;
  bf7_pkg::job_ctrl_t          job_ctrl;

  bf7_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .op        (op),
    .chan0     (chan0),
    .chan1     (chan1),
    .chan2     (chan2),
    .q_full    (q_full),
    .push      (push),
    .push_q    (push_q),
    .push_w    (push_w),
    .push_ctrl (push_ctrl),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data)
  );

  bf7_queue #(.WIDTH(JOB_W), .DEPTH(JOB_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctrl, push_w, push_q}),
    .pop       (job_pop),
    .full      (q_full),
    .not_empty (job_valid),
    .head      (job_head)
  );

  assign job_ctrl = job_head[JOB_W-1 -: CTL_W];

  bf7_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job_q     (job_head[AW-1:0]),
    .job_w     (job_head[AW +: WW]),
    .job_ctrl  (job_ctrl),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out0      (out0),
    .out1      (out1),
    .out2      (out2),
    .frame_end (frame_end)
  );

endmodule

>>> rtl/core/bf7_front.sv
// front end: config registers, input handshake, raster counters and ring bookkeeping
// decides which transactions produce a result and hands those to the job queue
// depends on bf7_pkg
`timescale 1ns / 1ps

module bf7_front #(
  parameter int MAX_WIDTH = 1024,
  localparam int RING = bf7_pkg::RING_ROWS * MAX_WIDTH,
  localparam int AW   = $clog2(RING),
  localparam int PW   = $clog2(RING + 1),
  localparam int CW   = $clog2(MAX_WIDTH),
  localparam int WW   = $clog2(MAX_WIDTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bf7_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bf7_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             pix_valid,
  output logic                             pix_ready,
  input  logic                             op,
  input  logic [bf7_pkg::PIX_W-1:0]        chan0,
  input  logic [bf7_pkg::PIX_W-1:0]        chan1,
  input  logic [bf7_pkg::PIX_W-1:0]        chan2,
  input  logic                             q_full,
  output logic                             push,
  output logic [AW-1:0]                    push_q,
  output logic [WW-1:0]                    push_w,
  output bf7_pkg::job_ctrl_t               push_ctrl,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_addr,
  output logic [bf7_pkg::PIXEL_W-1:0]      mem_data
);

  logic [bf7_pkg::FW_W-1:0]  frame_width;
  logic [bf7_pkg::ROW_W-1:0] frame_height;
  logic                      color_mode;

  logic [AW-1:0]             wr_pos;
  logic [PW-1:0]             pending;
  logic [PW-1:0]             closed;
  logic [CW-1:0]             in_col;
  logic [bf7_pkg::ROW_W-1:0] in_row;
  logic [CW-1:0]             out_col;
  logic [bf7_pkg::ROW_W-1:0] out_row;

  logic [WW-1:0]             eff_w;
  logic [bf7_pkg::ROW_W-1:0] eff_h;
  logic [PW-1:0]             thresh;
  logic [AW-1:0]             wr_next;
  logic [PW-1:0]             pend_inc;
  logic                      is_pixel;
  logic                      col_last;
  logic                      row_last;
  logic [PW-1:0]             pend_base;
  logic [AW-1:0]             addr_base;
  logic                      emit;
  logic [PW:0]               q_sum;
  logic [PW-1:0]             pend_after;
  logic [PW-1:0]             closed_after;
  logic [PW-1:0]             closed_next;
  logic                      frame_last;
  logic                      oc_last;
  logic                      or_last;
  logic                      accept;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h = (frame_height == '0) ? bf7_pkg::ROW_W'(1) : frame_height;
    thresh = PW'(bf7_pkg::RADIUS * 32'(eff_w) + bf7_pkg::RADIUS);
    wr_next = (32'(wr_pos) == RING - 1) ? '0 : wr_pos + 1'b1;
    pend_inc = (32'(pending) < RING) ? pending + 1'b1 : pending;
    is_pixel = (op == bf7_pkg::OP_PIXEL);
    col_last = (32'(in_col) + 1 >= 32'(eff_w));
    row_last = (32'(in_row) + 1 >= 32'(eff_h));
    if (is_pixel) begin
      pend_base = pend_inc;
      addr_base = wr_next;
      emit      = (pend_inc > thresh);
    end else begin
      pend_base = pending;
      addr_base = wr_pos;
      emit      = (closed != '0) && (pending != '0);
    end
    q_sum = (PW+1)'(addr_base) + (PW+1)'(RING) - (PW+1)'(pend_base);
    push_q = (32'(q_sum) >= RING) ? AW'(32'(q_sum) - RING) : AW'(q_sum);
    pend_after = emit ? pend_base - 1'b1 : pend_base;
    closed_after = (emit && closed != '0) ? closed - 1'b1 : closed;
    frame_last = is_pixel && col_last && row_last;
    closed_next = frame_last ? pend_after : closed_after;
    oc_last = (32'(out_col) + 1 >= 32'(eff_w));
    or_last = (32'(out_row) + 1 >= 32'(eff_h));
    push_ctrl.interior = (32'(out_row) >= bf7_pkg::RADIUS) &&
                         (32'(out_row) + bf7_pkg::RADIUS < 32'(eff_h)) &&
                         (32'(out_col) >= bf7_pkg::RADIUS) &&
                         (32'(out_col) + bf7_pkg::RADIUS < 32'(eff_w));
    push_ctrl.frame_end = oc_last && or_last;
    push_ctrl.color     = color_mode;
  end

  assign pix_ready = !q_full;
  assign accept    = pix_valid && pix_ready;
  assign push      = accept && emit;
  assign push_w    = eff_w;
  assign mem_we    = accept && is_pixel;
  assign mem_addr  = wr_pos;
  assign mem_data  = {chan2, chan1, chan0};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bf7_pkg::FRAME_WIDTH_RST;
      frame_height <= bf7_pkg::FRAME_HEIGHT_RST;
      color_mode   <= 1'b0;
      wr_pos       <= '0;
      pending      <= '0;
      closed       <= '0;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bf7_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[bf7_pkg::FW_W-1:0];
          bf7_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[bf7_pkg::ROW_W-1:0];
          bf7_pkg::REG_COLOR_MODE:   color_mode   <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (is_pixel) begin
          wr_pos <= wr_next;
          in_col <= col_last ? '0 : in_col + 1'b1;
          if (col_last) begin
            in_row <= row_last ? '0 : in_row + 1'b1;
          end
        end
        pending <= pend_after;
        closed  <= closed_next;
        if (emit) begin
          if (oc_last) begin
            out_col <= '0;
            out_row <= or_last ? '0 : out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/bf7_queue.sv
// small job queue between the front end and the filter engine
// has no dependency on bf7_pkg
`timescale 1ns / 1ps

module bf7_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (32'(count) == DEPTH);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/bf7_back.sv
// filter engine: pixel ring memory, window walk, weighted sums and divider
// takes jobs from bf7_queue and drives the result register; depends on bf7_pkg
`timescale 1ns / 1ps

module bf7_back #(
  parameter int MAX_WIDTH = 1024,
  localparam int RING = bf7_pkg::RING_ROWS * MAX_WIDTH,
  localparam int AW   = $clog2(RING),
  localparam int WW   = $clog2(MAX_WIDTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  output logic                          job_pop,
  input  logic [AW-1:0]                 job_q,
  input  logic [WW-1:0]                 job_w,
  input  bf7_pkg::job_ctrl_t            job_ctrl,
  input  logic                          mem_we,
  input  logic [AW-1:0]                 mem_addr,
  input  logic [bf7_pkg::PIXEL_W-1:0]   mem_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [bf7_pkg::PIX_W-1:0]     out0,
  output logic [bf7_pkg::PIX_W-1:0]     out1,
  output logic [bf7_pkg::PIX_W-1:0]     out2,
  output logic                          frame_end
);

  localparam int LANES = bf7_pkg::LANES;
  localparam int PW8   = bf7_pkg::PIX_W;
  localparam int WB    = bf7_pkg::WEIGHT_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_CENTRE, S_TAPS, S_WAIT, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [bf7_pkg::PIXEL_W-1:0] mem [RING];
  logic [bf7_pkg::PIXEL_W-1:0] rdata;
  logic [AW-1:0]               raddr;

  logic [AW-1:0]                   addr;
  logic [AW-1:0]                   row_start;
  logic [WW-1:0]                   w_r;
  bf7_pkg::job_ctrl_t              ctrl_r;
  logic [bf7_pkg::DIAM_W-1:0]      jj;
  logic [bf7_pkg::TAP_IDX_W-1:0]   tap;
  logic [PW8-1:0]                  cv   [LANES];
  logic [PW8-1:0]                  resv [LANES];

  logic                            p1_valid;
  logic [bf7_pkg::TAP_IDX_W-1:0]   p1_tap;
  logic                            p2_valid;
  logic [WB-1:0]                   p2_wt [LANES];
  logic [PW8-1:0]                  p2_v  [LANES];

  logic [bf7_pkg::NUM_W-1:0]       num [LANES];
  logic [bf7_pkg::DEN_W-1:0]       den [LANES];
  logic [bf7_pkg::NUM_W-1:0]       rem [LANES];
  logic [PW8-1:0]                  quo [LANES];
  logic [bf7_pkg::BIT_CNT_W-1:0]   bitcnt;

  logic                            issue;
  logic [AW:0]                     start_sum;
  logic [AW-1:0]                   start_addr;
  logic [AW-1:0]                   addr_inc;
  logic [AW:0]                     row_sum;
  logic [AW-1:0]                   row_next;
  logic [PW8-1:0]                  rd_lane [LANES];
  logic [PW8-1:0]                  diff    [LANES];
  logic [2*WB-1:0]                 prod    [LANES];
  logic [bf7_pkg::NUM_W-1:0]       sub     [LANES];
  logic [bf7_pkg::NUM_W-1:0]       rem_n   [LANES];
  logic [PW8-1:0]                  quo_n   [LANES];

  always_comb begin
    issue = (state == S_CENTRE && ctrl_r.interior) || (state == S_TAPS);
    raddr = (state == S_IDLE) ? job_q : addr;
    job_pop = (state == S_IDLE) && job_valid;
    start_sum = (AW+1)'(job_q) + (AW+1)'(RING) -
                (AW+1)'(bf7_pkg::RADIUS * 32'(job_w) + bf7_pkg::RADIUS);
    start_addr = (32'(start_sum) >= RING) ? AW'(32'(start_sum) - RING) : AW'(start_sum);
    addr_inc = (32'(addr) == RING - 1) ? '0 : addr + 1'b1;
    row_sum = (AW+1)'(row_start) + (AW+1)'(w_r);
    row_next = (32'(row_sum) >= RING) ? AW'(32'(row_sum) - RING) : AW'(row_sum);
    for (int l = 0; l < LANES; l++) begin
      rd_lane[l] = rdata[l*PW8 +: PW8];
      diff[l] = (rd_lane[l] > cv[l]) ? rd_lane[l] - cv[l] : cv[l] - rd_lane[l];
      prod[l] = (2*WB)'(bf7_pkg::RANGE_W[diff[l]]) * (2*WB)'(bf7_pkg::TAP_W[p1_tap]);
      sub[l] = bf7_pkg::NUM_W'(den[l]) << bitcnt;
      if (rem[l] >= sub[l]) begin
        rem_n[l] = rem[l] - sub[l];
        quo_n[l] = quo[l] | (PW8'(1) << bitcnt);
      end else begin
        rem_n[l] = rem[l];
        quo_n[l] = quo[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
      p1_tap   <= tap;
      for (int l = 0; l < LANES; l++) begin
        p2_wt[l] <= prod[l][2*WB-1:WB];
        p2_v[l]  <= rd_lane[l];
        if (p2_valid) begin
          num[l] <= num[l] + bf7_pkg::NUM_W'(p2_wt[l]) * bf7_pkg::NUM_W'(p2_v[l]);
          den[l] <= den[l] + bf7_pkg::DEN_W'(p2_wt[l]);
        end
      end
      if (res_valid && res_ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      if (issue) begin
        tap <= tap + 1'b1;
        if (32'(jj) == bf7_pkg::DIAM - 1) begin
          jj        <= '0;
          row_start <= row_next;
          addr      <= row_next;
        end else begin
          jj   <= jj + 1'b1;
          addr <= addr_inc;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            row_start <= start_addr;
            addr      <= start_addr;
            w_r       <= job_w;
            ctrl_r    <= job_ctrl;
            jj        <= '0;
            tap       <= '0;
            state     <= S_CENTRE;
          end
        end
        S_CENTRE: begin
          for (int l = 0; l < LANES; l++) begin
            cv[l]   <= rd_lane[l];
            resv[l] <= rd_lane[l];
            num[l]  <= '0;
            den[l]  <= '0;
          end
          state <= ctrl_r.interior ? S_TAPS : S_OUT;
        end
        S_TAPS: begin
          if (32'(tap) == bf7_pkg::TAPS - 1) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!p1_valid && !p2_valid) begin
            for (int l = 0; l < LANES; l++) begin
              rem[l] <= num[l];
              quo[l] <= '0;
            end
            bitcnt <= bf7_pkg::BIT_CNT_W'(PW8 - 1);
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          for (int l = 0; l < LANES; l++) begin
            rem[l] <= rem_n[l];
            quo[l] <= quo_n[l];
          end
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == '0) begin
            for (int l = 0; l < LANES; l++) begin
              resv[l] <= (den[l] == '0) ? cv[l] : quo_n[l];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            out0      <= resv[0];
            out1      <= ctrl_r.color ? resv[1] : '0;
            out2      <= ctrl_r.color ? resv[2] : '0;
            frame_end <= ctrl_r.frame_end;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/testbench.sv
// self-checking testbench for the 7x7 bilateral filter: directed frames, back-to-back
// frames with drains, size extremes, then random frames, against a built-in predictor
// depends on bf7_pkg and bilateral_filter_7x7
`timescale 1ns / 1ps

module testbench;

  localparam int NRAD  = 3;
  localparam int MAXW  = 1024;
  localparam int NRING = (2 * NRAD + 3) * MAXW;
  localparam int WB    = 16;

  typedef struct packed {
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic       frame_end;
  } result_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [bf7_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bf7_pkg::CFG_W-1:0]     cfg_data;
  logic                          pix_valid;
  logic                          pix_ready;
  logic                          op;
  logic [7:0]                    chan0;
  logic [7:0]                    chan1;
  logic [7:0]                    chan2;
  logic                          res_valid;
  logic                          res_ready;
  logic [7:0]                    out0;
  logic [7:0]                    out1;
  logic [7:0]                    out2;
  logic                          frame_end;

  bilateral_filter_7x7 dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .op(op),
    .chan0(chan0), .chan1(chan1), .chan2(chan2),
    .res_valid(res_valid), .res_ready(res_ready),
    .out0(out0), .out1(out1), .out2(out2), .frame_end(frame_end)
  );

  // filter state mirror
  longint unsigned range_w [256];
  longint unsigned space_w [2 * NRAD * NRAD + 1];
  logic [23:0]     line_ring [NRING];
  int              wr_pos, pending, closed;
  int              in_row, in_col, out_row, out_col;
  logic [10:0]     frame_width;
  logic [11:0]     frame_height;
  logic            color_mode;

  result_t expected_pixels [$];
  int      errors;
  int      burst_left;
  int      sent_items;
  bit      no_gaps;
  int      cyc;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #12ms;
    $display("[bilateral_filter_7x7] ERROR");
    $finish;
  end

  function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  function automatic longint unsigned q31_exp_neg_inv(longint unsigned n);
    longint unsigned sum;
    longint unsigned term;
    sum  = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int k = 1; k <= 8; k++) begin
      term = term / (n * k);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic longint unsigned q16_weight(longint unsigned g);
    longint unsigned w;
    w = (g + (64'd1 << (30 - WB))) >> (31 - WB);
    return (w > 64'hFFFF) ? 64'hFFFF : w;
  endfunction

  function automatic void build_weights();
    longint unsigned c, c2, g, m;
    c  = q31_exp_neg_inv(2 * 25 * 25);
    c2 = q31_mul(c, c);
    g  = 64'd1 << 31;
    m  = c;
    for (int d = 0; d < 256; d++) begin
      range_w[d] = q16_weight(g);
      g = q31_mul(g, m);
      m = q31_mul(m, c2);
    end
    c = q31_exp_neg_inv(2 * 9 * 9);
    g = 64'd1 << 31;
    for (int d = 0; d < 2 * NRAD * NRAD + 1; d++) begin
      space_w[d] = q16_weight(g);
      g = q31_mul(g, c);
    end
  endfunction

  function automatic int eff_w();
    if (frame_width == 0) return 1;
    return (frame_width > MAXW) ? MAXW : int'(frame_width);
  endfunction

  function automatic int eff_h();
    return (frame_height == 0) ? 1 : int'(frame_height);
  endfunction

  function automatic void filter_pixel_out();
    int              w, h, q, r, c, pos, nch;
    bit              interior;
    logic [7:0]      cv, v, diff;
    longint unsigned num, den, wt, res;
    logic [7:0]      outs [3];
    result_t         e;
    w = eff_w();
    h = eff_h();
    q = (wr_pos + NRING - (pending % NRING)) % NRING;
    r = out_row;
    c = out_col;
    interior = r >= NRAD && r + NRAD < h && c >= NRAD && c + NRAD < w;
    nch = color_mode ? 3 : 1;
    for (int ch = 0; ch < 3; ch++) begin
      cv = line_ring[q][8*ch +: 8];
      res = cv;
      if (ch >= nch) begin
        res = 0;
      end else if (interior) begin
        num = 0;
        den = 0;
        for (int i = -NRAD; i <= NRAD; i++) begin
          for (int j = -NRAD; j <= NRAD; j++) begin
            pos = (q + i * w + j + NRING) % NRING;
            v = line_ring[pos][8*ch +: 8];
            diff = (v > cv) ? v - cv : cv - v;
            wt = (range_w[diff] * space_w[i*i + j*j]) >> WB;
            num += wt * v;
            den += wt;
          end
        end
        res = den ? num / den : cv;
        if (res > 255) res = 255;
      end
      outs[ch] = res[7:0];
    end
    e.out0 = outs[0];
    e.out1 = outs[1];
    e.out2 = outs[2];
    e.frame_end = (c + 1 >= w) && (r + 1 >= h);
    expected_pixels.push_back(e);
    if (c + 1 >= w) begin
      out_col = 0;
      out_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      out_col = c + 1;
    end
    if (pending > 0) pending--;
    if (closed > 0) closed--;
  endfunction

  function automatic void filter_accept(logic o, logic [7:0] c0, logic [7:0] c1,
                                        logic [7:0] c2);
    int w, h;
    bit last;
    w = eff_w();
    h = eff_h();
    if (o == bf7_pkg::OP_DRAIN) begin
      if (closed > 0 && pending > 0) filter_pixel_out();
      return;
    end
    line_ring[wr_pos] = {c2, c1, c0};
    wr_pos = (wr_pos + 1) % NRING;
    if (pending < NRING) pending++;
    last = (in_col + 1 >= w) && (in_row + 1 >= h);
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
    end else begin
      in_col++;
    end
    if (pending > NRAD * w + NRAD) filter_pixel_out();
    if (last) closed = pending;
  endfunction

  task automatic send_item(logic o, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        pix_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    op        <= o;
    chan0     <= c0;
    chan1     <= c1;
    chan2     <= c2;
    do @(posedge clk); while (!pix_ready);
    filter_accept(o, c0, c1, c2);
    burst_left--;
    sent_items++;
  endtask

  task automatic write_reg(bf7_pkg::reg_index_t idx, logic [bf7_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bf7_pkg::REG_FRAME_WIDTH:  frame_width  = val[10:0];
      bf7_pkg::REG_FRAME_HEIGHT: frame_height = val[11:0];
      default:                   color_mode   = val[0];
    endcase
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    @(negedge clk);
    pix_valid <= 1'b0;
    while (expected_pixels.size() != 0 && n < 2000000) begin
      @(posedge clk);
      n++;
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, bit cm);
    wait_idle();
    write_reg(bf7_pkg::REG_FRAME_WIDTH, bf7_pkg::CFG_W'(w));
    write_reg(bf7_pkg::REG_FRAME_HEIGHT, bf7_pkg::CFG_W'(h));
    write_reg(bf7_pkg::REG_COLOR_MODE, bf7_pkg::CFG_W'(cm));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_value(int style, int base, int idx);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: return 8'((base + $urandom_range(0, 40) > 275) ? 255 : base + $urandom_range(0, 20));
      default: return (idx % 2) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // one frame of pixels, with stray drains mixed in at the given percentage
  task automatic send_frame(int noise_pct);
    int style, base, n;
    style = $urandom_range(0, 2);
    base  = $urandom_range(0, 255);
    n     = eff_w() * eff_h();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(bf7_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      send_item(bf7_pkg::OP_PIXEL, pick_value(style, base, k + k / eff_w()),
                pick_value(style, base, k), pick_value(style, base, k + 1));
    end
  endtask

  task automatic flush_frame();
    while (closed > 0 && pending > 0)
      send_item(bf7_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    send_item(bf7_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_drain_when_empty();
    send_item(bf7_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    send_item(bf7_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_small_frames();
    set_frame(7, 7, 1'b0);
    send_frame(0);
    flush_frame();
    set_frame(7, 7, 1'b1);
    send_frame(0);
    flush_frame();
    set_frame(0, 0, 1'b1);
    send_item(bf7_pkg::OP_PIXEL, 8'hA5, 8'h5A, 8'hFF);
    flush_frame();
  endtask

  task automatic test_size_extremes();
    set_frame(1, 40, 1'b0);
    no_gaps = 1;
    send_frame(0);
    no_gaps = 0;
    flush_frame();
    set_frame(40, 1, 1'b1);
    send_frame(1);
    flush_frame();
  endtask

  task automatic test_back_to_back();
    set_frame(9, 8, 1'b1);
    send_frame(0);
    send_frame(20);
    flush_frame();
  endtask

  task automatic test_random_frames();
    int start;
    start = sent_items;
    while (sent_items - start < 575) begin
      set_frame($urandom_range(0, 9) == 0 ? $urandom_range(1, 6) : $urandom_range(7, 16),
                $urandom_range(0, 9) == 0 ? $urandom_range(1, 6) : $urandom_range(7, 10),
                $urandom_range(0, 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      send_frame($urandom_range(0, 8));
      if ($urandom_range(0, 2) == 0) send_frame(5);
      flush_frame();
    end
    no_gaps = 0;
  endtask

  // receiver stall pattern: always ready, random, then long stalls
  always @(negedge clk) begin
    cyc <= cyc + 1;
    case ((cyc / 700) % 3)
      0:       res_ready <= 1'b1;
      1:       res_ready <= ($urandom_range(0, 99) < 60);
      default: res_ready <= ($urandom_range(0, 15) == 0) ? ~res_ready : res_ready;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected transaction: out0 %0d out1 %0d out2 %0d", out0, out1, out2);
        errors++;
      end else begin
        result_t e;
        e = expected_pixels.pop_front();
        if (out0 !== e.out0) begin
          $error("out0 expected %0d actual %0d", e.out0, out0);
          errors++;
        end
        if (out1 !== e.out1) begin
          $error("out1 expected %0d actual %0d", e.out1, out1);
          errors++;
        end
        if (out2 !== e.out2) begin
          $error("out2 expected %0d actual %0d", e.out2, out2);
          errors++;
        end
        if (frame_end !== e.frame_end) begin
          $error("frame_end expected %0d actual %0d", e.frame_end, frame_end);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_valid = 1'b0;
    op = bf7_pkg::OP_PIXEL;
    chan0 = '0;
    chan1 = '0;
    chan2 = '0;
    res_ready = 1'b1;
    cyc = 0;
    errors = 0;
    burst_left = 0;
    sent_items = 0;
    no_gaps = 0;
    build_weights();
    foreach (line_ring[k]) line_ring[k] = '0;
    wr_pos = 0; pending = 0; closed = 0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    frame_width = 11'd640;
    frame_height = 12'd480;
    color_mode = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_drain_when_empty();
    test_small_frames();
    test_back_to_back();
    test_size_extremes();
    test_random_frames();

    wait_idle();
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("[bilateral_filter_7x7] OK");
    end else begin
      if (expected_pixels.size() != 0)
        $error("%0d expected transactions never arrived", expected_pixels.size());
      $display("[bilateral_filter_7x7] ERROR");
    end
    $finish;
  end

endmodule
